/* design/wide_line_boundary_splitter_macros.svh */
// Assertion macros shared by the line splitter modules.
`ifndef WIDE_LINE_BOUNDARY_SPLITTER_MACROS_SVH
`define WIDE_LINE_BOUNDARY_SPLITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WLBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WLBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/wlbs_pkg.sv */
// Types, constants and helpers shared by the line splitter modules.
package wlbs_pkg;

   localparam int unsigned DATA_W    = 64;
   localparam int unsigned CNT_W     = 5;
   localparam int unsigned LINE_W    = 16;
   localparam int unsigned SUM_W     = 18;
   localparam logic [7:0]  DELIM_RST = 8'd10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic new_hit;
      logic final_hit;
      logic pending;
      logic out_free;
   } dp_status_type;

   function automatic logic [LINE_W-1:0] sat_line(logic [SUM_W-1:0] v,
                                                  logic [LINE_W-1:0] lim);
      logic [SUM_W-1:0] lim_ext;
      lim_ext = {{(SUM_W-LINE_W){1'b0}}, lim};
      if (v > lim_ext) begin
         return lim;
      end
      return v[LINE_W-1:0];
   endfunction

endpackage

/* design/wlbs_ctrl.sv */
// Controller state machine: accepts a word, then walks its delimiter hits.
`include "wide_line_boundary_splitter_macros.svh"

module wlbs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  wlbs_pkg::dp_status_type status,
   output wlbs_pkg::ctrl_cmd_type  cmd
);
   import wlbs_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept && status.new_hit) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.emit = status.out_free;
            if (status.out_free && status.final_hit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `WLBS_ASSERT_SAME(a_scan_has_hits, clock, reset, state_ff == ST_SCAN, status.pending, "scan without pending delimiters")
   `WLBS_ASSERT_NEXT(a_hit_enters_scan, clock, reset, accept && status.new_hit, state_ff == ST_SCAN, "word with delimiters did not enter scan")
   `WLBS_ASSERT_NEXT(a_last_returns_idle, clock, reset, cmd.emit && status.final_hit, state_ff == ST_IDLE, "scan did not end after last delimiter")

endmodule

/* design/wlbs_dp.sv */
// Datapath: delimiter compare, hit mask, line length and offset tracking, result register.
`include "wide_line_boundary_splitter_macros.svh"

module wlbs_dp #(
   parameter int unsigned LANES    = 16,
   parameter logic [15:0] LINE_MAX = 16'hFFFF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [wlbs_pkg::DATA_W-1:0]   data_lo,
   input  logic [wlbs_pkg::DATA_W-1:0]   data_hi,
   input  logic [wlbs_pkg::CNT_W-1:0]    byte_count,
   input  logic                          restart,
   input  logic                          csr_valid,
   input  logic [7:0]                    csr_data,
   input  wlbs_pkg::ctrl_cmd_type        cmd,
   output wlbs_pkg::dp_status_type       status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [wlbs_pkg::LINE_W-1:0]   line_length,
   output logic [wlbs_pkg::LINE_W-1:0]   line_offset,
   output logic                          last_of_item
);
   import wlbs_pkg::*;

   localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;
   localparam logic [CNT_W-1:0] LANES_CNT = CNT_W'(LANES);

   logic [2*DATA_W-1:0] word;
   logic [CNT_W-1:0]    cnt;
   logic [LANES-1:0]    hit_mask;
   logic [LINE_W-1:0]   base_carry;
   logic [LINE_W-1:0]   base_start;

   logic [7:0]          delim_ff;
   logic [LANES-1:0]    mask_ff, mask_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [LINE_W-1:0]   carried_ff, carried_in;
   logic [LINE_W-1:0]   start_ff, start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LINE_W-1:0]   rsp_len_ff, rsp_len_in;
   logic [LINE_W-1:0]   rsp_off_ff, rsp_off_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [LW-1:0]       lane;
   logic [CNT_W-1:0]    lane_cnt;
   logic [LANES-1:0]    mask_rest;
   logic [LINE_W-1:0]   emit_len;
   logic [CNT_W-1:0]    tail;

   assign word = {data_hi, data_lo};
   assign cnt  = (byte_count > LANES_CNT) ? LANES_CNT : byte_count;

   for (genvar i = 0; i < LANES; i++) begin : g_cmp
      assign hit_mask[i] = (CNT_W'(i) < cnt) && (word[8*i +: 8] == delim_ff);
   end

   assign base_carry = restart ? '0 : carried_ff;
   assign base_start = restart ? '0 : start_ff;

   // Lowest pending delimiter lane.
   always_comb begin
      lane = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            lane = LW'(i);
         end
      end
   end

   assign lane_cnt  = CNT_W'(lane);
   assign mask_rest = mask_ff & (mask_ff - 1'b1);
   assign emit_len  = sat_line(SUM_W'(carried_ff) + SUM_W'(lane_cnt - pos_ff), LINE_MAX);
   assign tail      = count_ff - lane_cnt - 1'b1;

   always_comb begin
      mask_in      = mask_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      carried_in   = carried_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_len_in   = rsp_len_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load) begin
         start_in = base_start;
         if (hit_mask == '0) begin
            carried_in = sat_line(SUM_W'(base_carry) + SUM_W'(cnt), LINE_MAX);
         end else begin
            carried_in = base_carry;
            mask_in    = hit_mask;
            pos_in     = '0;
            count_in   = cnt;
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = emit_len;
         rsp_off_in   = start_ff;
         rsp_last_in  = (mask_rest == '0);
         mask_in      = mask_rest;
         pos_in       = lane_cnt + 1'b1;
         start_in     = sat_line(SUM_W'(start_ff) + SUM_W'(emit_len) + SUM_W'(1), LINE_MAX);
         // After the final delimiter, the bytes behind it open the next line.
         carried_in   = (mask_rest == '0) ? sat_line(SUM_W'(tail), LINE_MAX) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff     <= DELIM_RST;
         mask_ff      <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         carried_ff   <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            delim_ff <= csr_data;
         end
         mask_ff      <= mask_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         carried_ff   <= carried_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_len_ff  <= rsp_len_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.new_hit   = (hit_mask != '0);
   assign status.final_hit = (mask_rest == '0);
   assign status.pending   = (mask_ff != '0);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign line_length  = rsp_len_ff;
   assign line_offset  = rsp_off_ff;
   assign last_of_item = rsp_last_ff;

   `WLBS_ASSERT_SAME(a_emit_needs_hit, clock, reset, cmd.emit, mask_ff != '0, "result emitted with no pending delimiter")
   `WLBS_ASSERT_NEXT(a_last_clears_mask, clock, reset, cmd.emit && status.final_hit, mask_ff == '0 && rsp_last_ff, "last result left hits pending")
   `WLBS_ASSERT_SAME(a_no_load_while_pending, clock, reset, cmd.load, mask_ff == '0, "word loaded while hits pending")

endmodule

/* design/wide_line_boundary_splitter.sv */
// Top level of the 16-byte line boundary splitter.
//
//   channel  | direction | handshake              | contents
//   req      | in        | req_tvalid/req_tready  | text word, byte count, restart
//   rsp      | out       | rsp_tvalid/rsp_tready  | line length and offset, last flag
//   csr      | in        | csr_valid/csr_ready    | delimiter byte
//
// A word with no delimiter leaves the controller idle, ready for the next word. A word with
// k delimiters: the accept cycle builds the hit mask, then one line result per cycle leaves
// through the single result register, except while rsp_tready is low and holds it.
// A word is accepted while an earlier result still waits in the result register.
// Reset is synchronous; it sets the delimiter to newline and clears line state.
// The delimiter is written at any transfer on the csr channel, csr_ready is always high.

module wide_line_boundary_splitter #(
   parameter int unsigned LANES        = 16,
   parameter int unsigned BUFFER_BYTES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // data_lo[63:0], data_hi[127:64], byte_count[132:128], zero pad
   input  logic         req_tuser,  // restart
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // line_length[15:0], line_offset[31:16]
   output logic         rsp_tlast,  // last_of_item
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);
   import wlbs_pkg::*;

   localparam logic [15:0] LINE_MAX =
      (BUFFER_BYTES - 1 > 65535) ? 16'hFFFF : 16'(BUFFER_BYTES - 1);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [LINE_W-1:0] line_length;
   logic [LINE_W-1:0] line_offset;

   assign csr_ready = 1'b1;

   wlbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wlbs_dp #(
      .LANES    (LANES),
      .LINE_MAX (LINE_MAX)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .data_lo      (req_tdata[63:0]),
      .data_hi      (req_tdata[127:64]),
      .byte_count   (req_tdata[132:128]),
      .restart      (req_tuser),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .line_length  (line_length),
      .line_offset  (line_offset),
      .last_of_item (rsp_tlast)
   );

   assign rsp_tdata = {line_offset, line_length};

endmodule
